FILE: rtl/core/stb_pkg.sv
`timescale 1ns / 1ps

package stb_pkg;

   // Source size limit and keyword buffer depth
   localparam longint unsigned MAX_SOURCE_BYTES = 64'd65536;
   localparam int KEYWORD_MAX_LEN = 6;
   localparam int KW_IDX_W = $clog2(KEYWORD_MAX_LEN);

   // Offsets and lengths stop here
   localparam logic [15:0] OFFSET_LIMIT =
      ((MAX_SOURCE_BYTES - 64'd1) < 64'd65535) ? 16'(MAX_SOURCE_BYTES - 64'd1) : 16'hFFFF;

   // Result queue
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   // Token classes
   localparam logic [5:0] KIND_AND       = 6'd11;
   localparam logic [5:0] KIND_OR        = 6'd12;
   localparam logic [5:0] KIND_FLOAT     = 6'd15;
   localparam logic [5:0] KIND_NUMBER    = 6'd16;
   localparam logic [5:0] KIND_IDENT     = 6'd17;
   localparam logic [5:0] KIND_PLUS_EQ   = 6'd18;
   localparam logic [5:0] KIND_PLUS      = 6'd19;
   localparam logic [5:0] KIND_MINUS_EQ  = 6'd20;
   localparam logic [5:0] KIND_MINUS     = 6'd21;
   localparam logic [5:0] KIND_POW       = 6'd22;
   localparam logic [5:0] KIND_STAR_EQ   = 6'd23;
   localparam logic [5:0] KIND_STAR      = 6'd24;
   localparam logic [5:0] KIND_EQEQ      = 6'd25;
   localparam logic [5:0] KIND_ASSIGN    = 6'd26;
   localparam logic [5:0] KIND_AMP       = 6'd27;
   localparam logic [5:0] KIND_VARIADIC  = 6'd28;
   localparam logic [5:0] KIND_DOT       = 6'd29;
   localparam logic [5:0] KIND_LPAREN    = 6'd30;
   localparam logic [5:0] KIND_RPAREN    = 6'd31;
   localparam logic [5:0] KIND_LCURLY    = 6'd32;
   localparam logic [5:0] KIND_RCURLY    = 6'd33;
   localparam logic [5:0] KIND_SEMI      = 6'd34;
   localparam logic [5:0] KIND_COMMA     = 6'd35;
   localparam logic [5:0] KIND_ERROR     = 6'd36;
   localparam logic [5:0] KIND_EOF       = 6'd37;

   // Keywords; kind equals table index. Text is right-justified, first char highest.
   localparam int KW_COUNT = 15;
   localparam int KW_TEXT_BYTES = 6;
   localparam logic [8*KW_TEXT_BYTES-1:0] KW_TEXT [KW_COUNT] = '{
      48'("let"), 48'("const"), 48'("if"), 48'("else"), 48'("while"),
      48'("int"), 48'("float"), 48'("string"), 48'("bool"), 48'("func"),
      48'("return"), 48'("and"), 48'("or"), 48'("true"), 48'("false")
   };
   localparam int KW_LEN [KW_COUNT] = '{3, 5, 2, 4, 5, 3, 5, 6, 4, 4, 6, 3, 2, 4, 5};

   typedef enum logic [11:0] {
      MODE_IDLE   = 12'b0000_0000_0001,
      MODE_NUM    = 12'b0000_0000_0010,
      MODE_NUMDOT = 12'b0000_0000_0100,
      MODE_IDENT  = 12'b0000_0000_1000,
      MODE_PLUS   = 12'b0000_0001_0000,
      MODE_MINUS  = 12'b0000_0010_0000,
      MODE_STAR   = 12'b0000_0100_0000,
      MODE_EQ     = 12'b0000_1000_0000,
      MODE_AMP    = 12'b0001_0000_0000,
      MODE_BAR    = 12'b0010_0000_0000,
      MODE_DOT1   = 12'b0100_0000_0000,
      MODE_DOT2   = 12'b1000_0000_0000
   } mode_type;

   typedef logic [KEYWORD_MAX_LEN-1:0][7:0] word_buf_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } tok_type;

   // Results of one accepted item, first in order
   typedef struct packed {
      logic [1:0] count;
      tok_type    first;
      tok_type    second;
   } push_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v < OFFSET_LIMIT) ? v + 16'd1 : OFFSET_LIMIT;
   endfunction

   function automatic tok_type make_tok(input logic [5:0] kind, input logic [15:0] start,
                                        input logic [15:0] length);
      tok_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = length;
      t.last   = 1'b0;
      return t;
   endfunction

   function automatic logic [5:0] classify_word(input word_buf_type wbuf,
                                                input logic [15:0] len,
                                                input logic too_long);
      logic [5:0] kind;
      logic       hit;
      kind = KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         hit = (len == 16'(KW_LEN[k])) && !too_long;
         for (int j = 0; j < KW_TEXT_BYTES; j++) begin
            if (j < KW_LEN[k]) begin
               if (wbuf[j] != KW_TEXT[k][(KW_LEN[k]-1-j)*8 +: 8]) begin
                  hit = 1'b0;
               end
            end
         end
         if (hit) begin
            kind = 6'(k);
         end
      end
      return kind;
   endfunction

endpackage

FILE: rtl/core/stb_req_if.sv
`timescale 1ns / 1ps

interface stb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       end_of_source;

   modport source (output valid, output source_byte, output end_of_source, input ready);
   modport sink (input valid, input source_byte, input end_of_source, output ready);
endinterface

FILE: rtl/core/stb_rsp_if.sv
`timescale 1ns / 1ps

interface stb_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_start, output token_length,
                   output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_start, input token_length,
                 input last_of_run, output ready);
endinterface

FILE: rtl/core/stb_scan.sv
`timescale 1ns / 1ps

// Per-byte lexer step: scan state registers plus the single-pass decision.
module stb_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          source_byte,
   input  logic                end_of_source,
   output stb_pkg::push_type   push
);

   stb_pkg::mode_type     mode_ff, mode_in;
   logic [15:0]           offset_ff, offset_in;
   logic [15:0]           begin_ff, begin_in;
   logic [15:0]           bytes_ff, bytes_in;
   logic                  too_long_ff, too_long_in;
   stb_pkg::word_buf_type wbuf_ff;

   logic                        buf_we;
   logic [stb_pkg::KW_IDX_W-1:0] buf_idx;

   logic c_space, c_digit, c_word;

   logic              flush_v;
   stb_pkg::tok_type  flush_tok;
   logic              ext_ok, ext_v;
   stb_pkg::tok_type  ext_tok;
   stb_pkg::mode_type ext_mode;
   logic              fresh_v;
   stb_pkg::tok_type  fresh_tok;
   stb_pkg::mode_type fresh_mode;

   logic              a_v, b_v;
   stb_pkg::tok_type  a_tok, b_tok;

   assign c_space = (source_byte == " ") || (source_byte >= 8'd9 && source_byte <= 8'd13);
   assign c_digit = (source_byte >= "0") && (source_byte <= "9");
   assign c_word  = (source_byte >= "a" && source_byte <= "z")
                 || (source_byte >= "A" && source_byte <= "Z")
                 || (source_byte == "_") || source_byte[7];

   // pending token emitted without lookahead
   always_comb begin
      flush_v   = 1'b1;
      flush_tok = stb_pkg::make_tok(stb_pkg::KIND_DOT, begin_ff, 16'd1);
      case (mode_ff)
         stb_pkg::MODE_NUM:
            flush_tok = stb_pkg::make_tok(stb_pkg::KIND_NUMBER, begin_ff, bytes_ff);
         stb_pkg::MODE_NUMDOT:
            flush_tok = stb_pkg::make_tok(stb_pkg::KIND_FLOAT, begin_ff, bytes_ff);
         stb_pkg::MODE_IDENT:
            flush_tok = stb_pkg::make_tok(
               stb_pkg::classify_word(wbuf_ff, bytes_ff, too_long_ff), begin_ff, bytes_ff);
         stb_pkg::MODE_PLUS:  flush_tok.kind = stb_pkg::KIND_PLUS;
         stb_pkg::MODE_MINUS: flush_tok.kind = stb_pkg::KIND_MINUS;
         stb_pkg::MODE_STAR:  flush_tok.kind = stb_pkg::KIND_STAR;
         stb_pkg::MODE_EQ:    flush_tok.kind = stb_pkg::KIND_ASSIGN;
         stb_pkg::MODE_AMP:   flush_tok.kind = stb_pkg::KIND_AMP;
         stb_pkg::MODE_DOT1:  flush_tok.kind = stb_pkg::KIND_DOT;
         default:             flush_v = 1'b0;
      endcase
   end

   // try to extend the pending token
   always_comb begin
      ext_ok   = 1'b0;
      ext_v    = 1'b0;
      ext_mode = stb_pkg::MODE_IDLE;
      ext_tok  = stb_pkg::make_tok(stb_pkg::KIND_PLUS_EQ, begin_ff, 16'd2);
      case (mode_ff)
         stb_pkg::MODE_NUM: begin
            ext_ok   = c_digit || (source_byte == ".");
            ext_mode = c_digit ? stb_pkg::MODE_NUM : stb_pkg::MODE_NUMDOT;
         end
         stb_pkg::MODE_NUMDOT: begin
            ext_ok   = c_digit;
            ext_mode = stb_pkg::MODE_NUMDOT;
         end
         stb_pkg::MODE_IDENT: begin
            ext_ok   = c_word || c_digit;
            ext_mode = stb_pkg::MODE_IDENT;
         end
         stb_pkg::MODE_PLUS: begin
            ext_ok = (source_byte == "=");
            ext_v  = ext_ok;
         end
         stb_pkg::MODE_MINUS: begin
            ext_ok       = (source_byte == "=");
            ext_v        = ext_ok;
            ext_tok.kind = stb_pkg::KIND_MINUS_EQ;
         end
         stb_pkg::MODE_STAR: begin
            ext_ok       = (source_byte == "=") || (source_byte == "*");
            ext_v        = ext_ok;
            ext_tok.kind = (source_byte == "*") ? stb_pkg::KIND_POW : stb_pkg::KIND_STAR_EQ;
         end
         stb_pkg::MODE_EQ: begin
            ext_ok       = (source_byte == "=");
            ext_v        = ext_ok;
            ext_tok.kind = stb_pkg::KIND_EQEQ;
         end
         stb_pkg::MODE_AMP: begin
            ext_ok       = (source_byte == "&");
            ext_v        = ext_ok;
            ext_tok.kind = stb_pkg::KIND_AND;
         end
         stb_pkg::MODE_BAR: begin
            ext_ok       = (source_byte == "|");
            ext_v        = ext_ok;
            ext_tok.kind = stb_pkg::KIND_OR;
         end
         stb_pkg::MODE_DOT1: begin
            ext_ok   = (source_byte == ".");
            ext_mode = stb_pkg::MODE_DOT2;
         end
         stb_pkg::MODE_DOT2: begin
            ext_ok  = (source_byte == ".");
            ext_v   = ext_ok;
            ext_tok = stb_pkg::make_tok(stb_pkg::KIND_VARIADIC, begin_ff, 16'd3);
         end
         default: ext_ok = 1'b0;
      endcase
   end

   // start a new token at this byte
   always_comb begin
      fresh_mode = stb_pkg::MODE_IDLE;
      fresh_v    = 1'b0;
      fresh_tok  = stb_pkg::make_tok(stb_pkg::KIND_ERROR, offset_ff, 16'd1);
      if (c_space) begin
         fresh_v = 1'b0;
      end else if (c_digit) begin
         fresh_mode = stb_pkg::MODE_NUM;
      end else if (c_word) begin
         fresh_mode = stb_pkg::MODE_IDENT;
      end else begin
         case (source_byte)
            "+": fresh_mode = stb_pkg::MODE_PLUS;
            "-": fresh_mode = stb_pkg::MODE_MINUS;
            "*": fresh_mode = stb_pkg::MODE_STAR;
            "=": fresh_mode = stb_pkg::MODE_EQ;
            "&": fresh_mode = stb_pkg::MODE_AMP;
            "|": fresh_mode = stb_pkg::MODE_BAR;
            ".": fresh_mode = stb_pkg::MODE_DOT1;
            "(": begin fresh_v = 1'b1; fresh_tok.kind = stb_pkg::KIND_LPAREN; end
            ")": begin fresh_v = 1'b1; fresh_tok.kind = stb_pkg::KIND_RPAREN; end
            "{": begin fresh_v = 1'b1; fresh_tok.kind = stb_pkg::KIND_LCURLY; end
            "}": begin fresh_v = 1'b1; fresh_tok.kind = stb_pkg::KIND_RCURLY; end
            ";": begin fresh_v = 1'b1; fresh_tok.kind = stb_pkg::KIND_SEMI; end
            ",": begin fresh_v = 1'b1; fresh_tok.kind = stb_pkg::KIND_COMMA; end
            default: fresh_v = 1'b1;
         endcase
      end
   end

   // choose the path, next state and up to two results
   always_comb begin
      mode_in     = mode_ff;
      offset_in   = stb_pkg::sat_inc(offset_ff);
      begin_in    = begin_ff;
      bytes_in    = bytes_ff;
      too_long_in = too_long_ff;
      buf_we      = 1'b0;
      buf_idx     = '0;
      a_v         = 1'b0;
      a_tok       = flush_tok;
      b_v         = 1'b0;
      b_tok       = ext_tok;
      if (end_of_source) begin
         a_v       = flush_v;
         b_v       = 1'b1;
         b_tok     = stb_pkg::make_tok(stb_pkg::KIND_EOF, offset_ff, 16'd0);
         mode_in   = stb_pkg::MODE_IDLE;
         offset_in = '0;
      end else if (ext_ok) begin
         b_v     = ext_v;
         mode_in = ext_mode;
         if (mode_ff == stb_pkg::MODE_NUM || mode_ff == stb_pkg::MODE_NUMDOT ||
             mode_ff == stb_pkg::MODE_IDENT) begin
            bytes_in = stb_pkg::sat_inc(bytes_ff);
         end
         if (mode_ff == stb_pkg::MODE_IDENT) begin
            if (bytes_ff < 16'(stb_pkg::KEYWORD_MAX_LEN)) begin
               buf_we  = 1'b1;
               buf_idx = bytes_ff[stb_pkg::KW_IDX_W-1:0];
            end else begin
               too_long_in = 1'b1;
            end
         end
      end else begin
         a_v      = flush_v;
         b_v      = fresh_v;
         b_tok    = fresh_tok;
         mode_in  = fresh_mode;
         begin_in = offset_ff;
         bytes_in = 16'd1;
         if (fresh_mode == stb_pkg::MODE_IDENT) begin
            buf_we      = 1'b1;
            too_long_in = 1'b0;
         end
      end
   end

   always_comb begin
      push.count  = accept ? {a_v & b_v, a_v ^ b_v} : 2'd0;
      push.first  = a_v ? a_tok : b_tok;
      push.second = b_tok;
      if (a_v && b_v) begin
         push.second.last = 1'b1;
      end else begin
         push.first.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= stb_pkg::MODE_IDLE;
         offset_ff   <= '0;
         begin_ff    <= '0;
         bytes_ff    <= '0;
         too_long_ff <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         offset_ff   <= offset_in;
         begin_ff    <= begin_in;
         bytes_ff    <= bytes_in;
         too_long_ff <= too_long_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !end_of_source && buf_we) begin
         wbuf_ff[buf_idx] <= source_byte;
      end
   end

endmodule

FILE: rtl/core/stb_out_queue.sv
`timescale 1ns / 1ps

// Small result queue: takes up to two tokens a cycle, hands out one.
module stb_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  stb_pkg::push_type push,
   output logic              room,
   output logic              out_valid,
   input  logic              out_ready,
   output stb_pkg::tok_type  out_tok
);

   stb_pkg::tok_type                 slot_ff [stb_pkg::OUTQ_DEPTH];
   logic [stb_pkg::OUTQ_PTR_W-1:0]   wr_ff, wr_in;
   logic [stb_pkg::OUTQ_PTR_W-1:0]   rd_ff, rd_in;
   logic [stb_pkg::OUTQ_CNT_W-1:0]   count_ff, count_in;
   logic                             pop;

   assign room      = count_ff <= stb_pkg::OUTQ_CNT_W'(stb_pkg::OUTQ_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_tok   = slot_ff[rd_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in    = wr_ff + stb_pkg::OUTQ_PTR_W'(push.count);
      rd_in    = rd_ff + stb_pkg::OUTQ_PTR_W'(pop);
      count_in = count_ff + stb_pkg::OUTQ_CNT_W'(push.count) - stb_pkg::OUTQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ff + stb_pkg::OUTQ_PTR_W'(1)] <= push.second;
      end
   end

endmodule

FILE: rtl/core/source_byte_tokenizer_core.sv
`timescale 1ns / 1ps

// Streaming lexer: one source byte per item on req_chan, tokens out on rsp_chan as
// (token_kind, token_start, token_length) with no lexeme text. Whitespace is skipped;
// numbers, identifiers (keyword-matched up to six bytes) and one- to three-byte
// operators are recognized with one byte of lookahead, so a token usually leaves when
// the byte after it arrives. An item with end_of_source set flushes the pending token,
// emits the end-of-file token at the byte count and restarts offsets at zero. One item
// can yield up to two tokens; last_of_run marks the final one. Rate: one item per cycle
// while the result queue has room, since the whole per-byte decision is combinational
// behind the scan state registers; the four-entry result queue takes an item whenever
// it holds two or fewer tokens. Offsets and lengths saturate at 65535.
module source_byte_tokenizer_core (
   input  logic       clock,
   input  logic       reset,
   stb_req_if.sink    req_chan,
   stb_rsp_if.source  rsp_chan
);

   logic              accept;
   logic              room;
   stb_pkg::push_type push;
   stb_pkg::tok_type  out_tok;

   // input side only waits on queue space
   assign req_chan.ready = room;
   assign accept         = req_chan.valid && room;

   stb_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .source_byte   (req_chan.source_byte),
      .end_of_source (req_chan.end_of_source),
      .push          (push)
   );

   stb_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_tok   (out_tok)
   );

   assign rsp_chan.token_kind   = out_tok.kind;
   assign rsp_chan.token_start  = out_tok.start;
   assign rsp_chan.token_length = out_tok.length;
   assign rsp_chan.last_of_run  = out_tok.last;

endmodule
